### design/esfe_pkg.sv
// ----------------------------------------------------------------------------
// esfe_pkg
// Shared types, constants and helpers of the escaped segmented frame encoder.
// ----------------------------------------------------------------------------
package esfe_pkg;

    // Segment size in split mode
    localparam int SEGMENT_MAX = 128;

    // Framing bytes
    localparam logic [7:0] SOF_BYTE   = 8'h01;
    localparam logic [7:0] ESC_BYTE   = 8'h02;
    localparam logic [7:0] EOF_BYTE   = 8'h03;
    localparam logic [7:0] ESC_OFFSET = 8'h04;
    localparam logic [7:0] SEG_HDR_PAD = 8'h00;

    // Header length field carries segment length plus this
    localparam logic [15:0] SEG_LEN_EXTRA = 16'd8;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_SPLIT_MODE   = 2'd0;
    localparam logic [1:0] REG_COMMAND_CODE = 2'd1;
    localparam logic [1:0] REG_SUB_CODE     = 2'd2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Output run slots, in emission order
    localparam int NUM_SLOTS = 13;
    localparam int IDX_W     = $clog2(NUM_SLOTS);

    localparam logic [IDX_W-1:0] SLOT_SOF    = IDX_W'(0);
    localparam logic [IDX_W-1:0] SLOT_LEN_HI = IDX_W'(1);
    localparam logic [IDX_W-1:0] SLOT_LEN_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] SLOT_HDR0   = IDX_W'(3);
    localparam logic [IDX_W-1:0] SLOT_DATA   = IDX_W'(10);
    localparam logic [IDX_W-1:0] SLOT_CKSUM  = IDX_W'(11);
    localparam logic [IDX_W-1:0] SLOT_EOF    = IDX_W'(12);

    localparam int HDR_BYTES = 7;

    typedef struct packed {
        logic       split_mode;
        logic [7:0] command_code;
        logic [7:0] sub_code;
    } cfg_t;

    // One slot sends one byte, or two when escaped
    typedef struct packed {
        logic       present;
        logic       esc;
        logic [7:0] val;
    } slot_t;

    typedef slot_t [NUM_SLOTS-1:0] run_t;

    function automatic logic needs_esc(input logic [7:0] v);
        needs_esc = (v >= SOF_BYTE) && (v <= EOF_BYTE);
    endfunction

endpackage

### design/esfe_if.sv
// ----------------------------------------------------------------------------
// esfe_in_if / esfe_out_if
// Valid/ready channels for message bytes in and serial bytes out.
// ----------------------------------------------------------------------------
interface esfe_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] message_length;

    modport source (output valid, output data_byte, output message_length, input ready);
    modport sink   (input valid, input data_byte, input message_length, output ready);
endinterface

interface esfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_end,
                    output ready);
endinterface

### design/escaped_segmented_frame_encoder.sv
// The first byte of a run is offered in the cycle after its input beat is taken.
// Throughput: one output byte per cycle while out_ch.ready is high; an input beat
// yields a run of 1 to 23 bytes, and holds the input off until its run is sent.
// The next input beat is taken in the cycle the last byte of a run is taken.
// Reset: message and segment state clear, split mode off, command code 2, sub code 0.
// ----------------------------------------------------------------------------
// escaped_segmented_frame_encoder
// Byte-stuffing frame encoder with optional segmentation and XOR checksum.
// ----------------------------------------------------------------------------
module escaped_segmented_frame_encoder (
    input  logic                              clk,
    input  logic                              rst_n,
    esfe_in_if.sink                           in_ch,
    esfe_out_if.source                        out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [esfe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [esfe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [esfe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    esfe_pkg::cfg_t cfg;
    esfe_pkg::run_t run;
    logic           take_ready;
    logic           accept;

    assign in_ch.ready = take_ready;
    assign accept      = in_ch.valid && take_ready;

    // Registers
    esfe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Build the run for each beat
    esfe_build u_build (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (in_ch.data_byte),
        .message_length (in_ch.message_length),
        .cfg            (cfg),
        .run            (run)
    );

    // Send the run
    esfe_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .run_in     (run),
        .take_ready (take_ready),
        .out_ch     (out_ch)
    );

endmodule

### design/esfe_cfg.sv
// ----------------------------------------------------------------------------
// esfe_cfg
// APB register file: split mode, command code and sub code.
// ----------------------------------------------------------------------------
module esfe_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [esfe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [esfe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [esfe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output esfe_pkg::cfg_t                    cfg
);

    esfe_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_mode   <= 1'b0;
            cfg_reg.command_code <= 8'd2;
            cfg_reg.sub_code     <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                esfe_pkg::REG_SPLIT_MODE:   cfg_reg.split_mode   <= pwdata[0];
                esfe_pkg::REG_COMMAND_CODE: cfg_reg.command_code <= pwdata[7:0];
                esfe_pkg::REG_SUB_CODE:     cfg_reg.sub_code     <= pwdata[7:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            esfe_pkg::REG_SPLIT_MODE:   prdata = {31'd0, cfg_reg.split_mode};
            esfe_pkg::REG_COMMAND_CODE: prdata = {24'd0, cfg_reg.command_code};
            esfe_pkg::REG_SUB_CODE:     prdata = {24'd0, cfg_reg.sub_code};
            default:                    prdata = '0;
        endcase
    end

endmodule

### design/esfe_build.sv
// ----------------------------------------------------------------------------
// esfe_build
// Frame state and run builder: turns one message byte into the slots of
// its output run and advances message and segment state.
// ----------------------------------------------------------------------------
module esfe_build (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic [15:0]    message_length,
    input  esfe_pkg::cfg_t cfg,
    output esfe_pkg::run_t run
);

    logic [15:0] mpos_reg, mpos_next;
    logic [7:0]  spos_reg, spos_next;
    logic [7:0]  snum_reg, snum_next;
    logic [7:0]  xor_reg,  xor_next;

    logic [16:0] total;
    logic [16:0] pos_ext;
    logic [16:0] remain;
    logic        msg_last;
    logic        seg_start;
    logic        seg_last;
    logic [15:0] thislen;
    logic [15:0] slen;
    logic [7:0]  hdr [esfe_pkg::HDR_BYTES];
    logic [7:0]  hdr_xor;
    logic [7:0]  new_xor;
    logic [7:0]  len_hi;
    logic [7:0]  len_lo;
    logic        head_on;

    function automatic esfe_pkg::slot_t mk(input logic on, input logic escapable,
                                           input logic [7:0] v);
        esfe_pkg::slot_t s;
        s.present = on;
        s.esc     = escapable && esfe_pkg::needs_esc(v);
        s.val     = v;
        mk = s;
    endfunction

    // Message bookkeeping
    assign total    = (message_length == 16'd0) ? 17'h10000 : {1'b0, message_length};
    assign pos_ext  = {1'b0, mpos_reg};
    assign msg_last = (pos_ext + 17'd1) >= total;
    assign remain   = total - pos_ext;

    // Segment length for a new header
    always_comb
    begin
        priority if (pos_ext >= total)
            thislen = 16'd1;
        else if (remain > 17'(esfe_pkg::SEGMENT_MAX))
            thislen = 16'(esfe_pkg::SEGMENT_MAX);
        else
            thislen = remain[15:0];
    end

    assign slen      = thislen + esfe_pkg::SEG_LEN_EXTRA;
    assign seg_start = (spos_reg == 8'd0);
    assign seg_last  = msg_last
                       || (({1'b0, spos_reg} + 9'd1) >= 9'(esfe_pkg::SEGMENT_MAX));

    // Segment header and checksum
    assign hdr[0] = cfg.command_code;
    assign hdr[1] = cfg.sub_code;
    assign hdr[2] = message_length[15:8];
    assign hdr[3] = message_length[7:0];
    assign hdr[4] = esfe_pkg::SEG_HDR_PAD;
    assign hdr[5] = snum_reg;
    assign hdr[6] = thislen[7:0];
    assign hdr_xor = hdr[1] ^ hdr[2] ^ hdr[3] ^ hdr[4] ^ hdr[5] ^ hdr[6];
    assign new_xor = (seg_start ? hdr_xor : xor_reg) ^ data_byte;

    // Fill run slots
    always_comb
    begin
        if (cfg.split_mode)
        begin
            head_on = seg_start;
            len_hi  = slen[15:8];
            len_lo  = slen[7:0];
        end
        else
        begin
            head_on = (mpos_reg == 16'd0);
            len_hi  = message_length[15:8];
            len_lo  = message_length[7:0];
        end
        run[esfe_pkg::SLOT_SOF]    = mk(head_on, 1'b0, esfe_pkg::SOF_BYTE);
        run[esfe_pkg::SLOT_LEN_HI] = mk(head_on, 1'b1, len_hi);
        run[esfe_pkg::SLOT_LEN_LO] = mk(head_on, 1'b1, len_lo);
        for (int k = 0; k < esfe_pkg::HDR_BYTES; k++)
        begin
            run[int'(esfe_pkg::SLOT_HDR0) + k] =
                mk(cfg.split_mode && seg_start, 1'b1, hdr[k]);
        end
        run[esfe_pkg::SLOT_DATA]  = mk(1'b1, 1'b1, data_byte);
        run[esfe_pkg::SLOT_CKSUM] = mk(cfg.split_mode && seg_last, 1'b0, new_xor);
        run[esfe_pkg::SLOT_EOF]   = mk(cfg.split_mode ? seg_last : msg_last, 1'b0,
                                       esfe_pkg::EOF_BYTE);
    end

    // Next state
    always_comb
    begin
        mpos_next = mpos_reg;
        spos_next = spos_reg;
        snum_next = snum_reg;
        xor_next  = xor_reg;
        if (cfg.split_mode)
        begin
            if (seg_last)
            begin
                spos_next = 8'd0;
                snum_next = snum_reg + 8'd1;
                xor_next  = 8'd0;
            end
            else
            begin
                spos_next = spos_reg + 8'd1;
                xor_next  = new_xor;
            end
        end
        if (msg_last)
        begin
            mpos_next = 16'd0;
            spos_next = 8'd0;
            snum_next = 8'd0;
            xor_next  = 8'd0;
        end
        else
        begin
            mpos_next = mpos_reg + 16'd1;
        end
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpos_reg <= 16'd0;
            spos_reg <= 8'd0;
            snum_reg <= 8'd0;
            xor_reg  <= 8'd0;
        end
        else if (accept)
        begin
            mpos_reg <= mpos_next;
            spos_reg <= spos_next;
            snum_reg <= snum_next;
            xor_reg  <= xor_next;
        end
    end

`ifndef ASSERT_OFF
    a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && msg_last |=> (mpos_reg == 16'd0) && (spos_reg == 8'd0)
                               && (snum_reg == 8'd0) && (xor_reg == 8'd0))
        else $error("state not cleared at message end");
`endif

endmodule

### design/esfe_serializer.sv
// ----------------------------------------------------------------------------
// esfe_serializer
// Run buffer: holds the slots of one run and sends one byte per beat,
// expanding escaped slots into two bytes.
// ----------------------------------------------------------------------------
module esfe_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  esfe_pkg::run_t    run_in,
    output logic              take_ready,
    esfe_out_if.source        out_ch
);

    localparam int IW = esfe_pkg::IDX_W;

    esfe_pkg::run_t  slot_reg;
    logic            busy_reg;
    logic [IW-1:0]   idx_reg;
    logic            half_reg;

    esfe_pkg::slot_t cur;
    logic            nxt_found;
    logic [IW-1:0]   nxt_idx;
    logic            first_found;
    logic [IW-1:0]   first_idx;
    logic            last_byte;
    logic            fire;

    // Lowest present slot at or above start
    function automatic logic [IW:0] find_from(input esfe_pkg::run_t r,
                                              input logic [IW-1:0] start);
        logic [IW:0] res;
        res = '0;
        for (int i = esfe_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (r[i].present && (IW'(i) >= start))
                res = {1'b1, IW'(i)};
        end
        find_from = res;
    endfunction

    assign cur = slot_reg[idx_reg];
    assign {nxt_found, nxt_idx}     = find_from(slot_reg, idx_reg + IW'(1));
    assign {first_found, first_idx} = find_from(run_in, '0);

    assign last_byte  = (!cur.esc || half_reg) && !nxt_found;
    assign fire       = out_ch.valid && out_ch.ready;
    assign take_ready = !busy_reg || (fire && last_byte);

    // Drive the current byte
    assign out_ch.valid     = busy_reg;
    assign out_ch.out_byte  = !cur.esc ? cur.val
                              : (half_reg ? cur.val + esfe_pkg::ESC_OFFSET
                                          : esfe_pkg::ESC_BYTE);
    assign out_ch.run_last  = last_byte;
    assign out_ch.frame_end = (idx_reg == esfe_pkg::SLOT_EOF);

    // Hold run payload
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= run_in;
    end

    // Walk the run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            half_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg <= first_found;
            idx_reg  <= first_idx;
            half_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (cur.esc && !half_reg)
                half_reg <= 1'b1;
            else if (nxt_found)
            begin
                idx_reg  <= nxt_idx;
                half_reg <= 1'b0;
            end
            else
                busy_reg <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg)
        else $error("run loaded but not sending");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !out_ch.run_last |=> out_ch.valid)
        else $error("run stopped before its last beat");

    a_frame_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_end |-> out_ch.out_byte == esfe_pkg::EOF_BYTE
                                             && out_ch.run_last)
        else $error("frame end on wrong byte");

    a_half_escaped: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && half_reg |-> cur.esc)
        else $error("second half of an unescaped slot");
`endif

endmodule

### bench/tb_escaped_segmented_frame_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escaped_segmented_frame_encoder
// Self-checking bench for the escaped segmented frame encoder. Message bytes
// go in through the input channel, and every serial byte that comes out is
// compared with a bit-true software encoder that runs alongside. Plain and
// split framing, escaping, checksums, length and mode changes inside a
// message, segment boundaries and back-pressure are each covered by a named
// test, followed by randomized message traffic.
// ----------------------------------------------------------------------------
module tb_escaped_segmented_frame_encoder;

    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_PAD       = 4;
    localparam int TAIL_CYCLES     = 40;
    localparam int RANDOM_ITEMS    = 100;
    localparam int MAX_REPORTS     = 60;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } serial_beat_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [esfe_pkg::APB_ADDR_W-1:0] paddr;
    logic [esfe_pkg::APB_DATA_W-1:0] pwdata;
    logic [esfe_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    esfe_in_if  in_ch ();
    esfe_out_if out_ch ();

    escaped_segmented_frame_encoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register copies and encoder state of the software encoder
    logic        cfg_split = 1'b0;
    logic [7:0]  cfg_cmd   = 8'h02;
    logic [7:0]  cfg_sub   = 8'h00;
    logic [15:0] msg_pos   = 16'd0;
    logic [7:0]  seg_pos   = 8'd0;
    logic [7:0]  seg_num   = 8'd0;
    logic [7:0]  seg_xor   = 8'h00;

    serial_beat_t run_q[$];
    serial_beat_t pending_serial_q[$];

    int          mismatches  = 0;
    int unsigned items_sent  = 0;
    int          idle_cycles = 0;
    bit          quiet       = 1'b0;
    bit          hold_off    = 1'b0;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    function automatic int unsigned draw_gap();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Favor the escaped values and the bytes 0 and 4 around them
    function automatic logic [7:0] draw_data();
        return ($urandom_range(0, 9) < 3) ? 8'($urandom_range(0, 4))
                                          : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] draw_code();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(1, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void stage_raw(input logic [7:0] b, input logic fe);
        serial_beat_t beat;
        beat.out_byte  = b;
        beat.run_last  = 1'b0;
        beat.frame_end = fe;
        run_q.push_back(beat);
    endfunction

    // Byte-stuff 1, 2 and 3 as ESC followed by value plus offset
    function automatic void stage_esc(input logic [7:0] b);
        if (b >= esfe_pkg::SOF_BYTE && b <= esfe_pkg::EOF_BYTE)
        begin
            stage_raw(esfe_pkg::ESC_BYTE, 1'b0);
            stage_raw(b + esfe_pkg::ESC_OFFSET, 1'b0);
        end
        else
            stage_raw(b, 1'b0);
    endfunction

    // Encode one message byte and queue the serial beats it must produce
    function automatic void encode_message_byte(input logic [7:0] data, input logic [15:0] len);
        int unsigned  total;
        int unsigned  pos;
        int unsigned  seg_len;
        logic         msg_last;
        logic         seg_last;
        serial_beat_t beat;
        run_q.delete();
        total    = (len == 16'd0) ? 65536 : int'(len);
        pos      = int'(msg_pos);
        msg_last = (pos + 1 >= total);
        if (!cfg_split)
        begin
            if (pos == 0)
            begin
                stage_raw(esfe_pkg::SOF_BYTE, 1'b0);
                stage_esc(len[15:8]);
                stage_esc(len[7:0]);
            end
            stage_esc(data);
            if (msg_last)
                stage_raw(esfe_pkg::EOF_BYTE, 1'b1);
        end
        else
        begin
            // Open a segment: SOF, frame length, seven header bytes
            if (seg_pos == 8'd0)
            begin
                if (pos >= total)
                    seg_len = 1;
                else if (total - pos > esfe_pkg::SEGMENT_MAX)
                    seg_len = esfe_pkg::SEGMENT_MAX;
                else
                    seg_len = total - pos;
                stage_raw(esfe_pkg::SOF_BYTE, 1'b0);
                stage_esc(8'((seg_len + 8) >> 8));
                stage_esc(8'(seg_len + 8));
                stage_esc(cfg_cmd);
                stage_esc(cfg_sub);
                stage_esc(len[15:8]);
                stage_esc(len[7:0]);
                stage_esc(esfe_pkg::SEG_HDR_PAD);
                stage_esc(seg_num);
                stage_esc(8'(seg_len));
                seg_xor = cfg_sub ^ len[15:8] ^ len[7:0] ^ esfe_pkg::SEG_HDR_PAD
                          ^ seg_num ^ 8'(seg_len);
            end
            seg_xor = seg_xor ^ data;
            stage_esc(data);
            seg_last = msg_last || (int'(seg_pos) + 1 >= esfe_pkg::SEGMENT_MAX);
            // Close the segment with the raw checksum and EOF
            if (seg_last)
            begin
                stage_raw(seg_xor, 1'b0);
                stage_raw(esfe_pkg::EOF_BYTE, 1'b1);
                seg_pos = 8'd0;
                seg_num = seg_num + 8'd1;
                seg_xor = 8'h00;
            end
            else
                seg_pos = seg_pos + 8'd1;
        end
        if (msg_last)
        begin
            msg_pos = 16'd0;
            seg_pos = 8'd0;
            seg_num = 8'd0;
            seg_xor = 8'h00;
        end
        else
            msg_pos = 16'(pos + 1);
        foreach (run_q[i])
        begin
            beat          = run_q[i];
            beat.run_last = (i == run_q.size() - 1);
            pending_serial_q.push_back(beat);
        end
    endfunction

    // Predict on every accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            encode_message_byte(in_ch.data_byte, in_ch.message_length);
    end

    // Compare every accepted output beat with the oldest prediction
    always @(posedge clk)
    begin : serial_checker
        serial_beat_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_serial_q.size() == 0)
                report_mismatch("out_byte with nothing pending", out_ch.out_byte, 0);
            else
            begin
                want = pending_serial_q.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
                if (out_ch.run_last !== want.run_last)
                    report_mismatch("run_last", out_ch.run_last, want.run_last);
                if (out_ch.frame_end !== want.frame_end)
                    report_mismatch("frame_end", out_ch.frame_end, want.frame_end);
            end
        end
    end

    // End the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || psel === 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("escaped_segmented_frame_encoder: mismatch");
                $finish;
            end
        end
    end

    // Output side: random ready gaps, plus one long hold-off on request
    initial
    begin : serial_receiver
        int unsigned gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            gap = draw_gap();
            if (gap != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
        end
    end

    // Offer one message byte and hold it until the encoder takes it
    task automatic send_byte(input logic [7:0] data, input logic [15:0] len);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= data;
        in_ch.message_length <= len;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random_bytes(input int unsigned count, input logic [15:0] len);
        repeat (count) send_byte(draw_data(), len);
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic drain_encoder();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_serial_q.size() != 0) @(posedge clk);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    // APB write, then read back; only called while the encoder is idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        want = (idx == esfe_pkg::REG_SPLIT_MODE) ? (value & 32'h1) : (value & 32'hFF);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        case (idx)
            esfe_pkg::REG_SPLIT_MODE:   cfg_split = want[0];
            esfe_pkg::REG_COMMAND_CODE: cfg_cmd   = want[7:0];
            esfe_pkg::REG_SUB_CODE:     cfg_sub   = want[7:0];
            default: ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        if (prdata !== want)
            report_mismatch("prdata", prdata, want);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Plain frames from reset settings: escapes, length extremes, early end
    task automatic test_plain_frames();
        send_byte(8'h00, 16'd1);
        send_byte(8'hFF, 16'd1);
        send_byte(8'h01, 16'd1);
        send_byte(8'h02, 16'd1);
        send_byte(8'h03, 16'd1);
        // length bytes both escaped, message cut short by a smaller length
        send_byte(8'h04, 16'h0203);
        send_byte(8'h00, 16'h0203);
        send_byte(8'h03, 16'd2);
        // zero length stands for 65536 bytes
        send_byte(8'h55, 16'h0000);
        send_byte(8'hAA, 16'h0000);
        send_byte(8'h80, 16'd1);
        send_byte(8'hFE, 16'hFFFF);
        send_byte(8'h7F, 16'd1);
        drain_encoder();
    endtask

    // Split frames: checksum of 1, 2 and 3 stays raw, escaped header codes
    task automatic test_split_frames();
        write_reg(esfe_pkg::REG_SPLIT_MODE, 32'h1);
        write_reg(esfe_pkg::REG_COMMAND_CODE, 32'h3);
        write_reg(esfe_pkg::REG_SUB_CODE, 32'h0);
        send_byte(8'h01, 16'd1);
        send_byte(8'h02, 16'd1);
        send_byte(8'h03, 16'd1);
        drain_encoder();
        write_reg(esfe_pkg::REG_COMMAND_CODE, 32'h0);
        write_reg(esfe_pkg::REG_SUB_CODE, 32'hFF);
        send_byte(8'h02, 16'd3);
        send_byte(8'hFF, 16'd3);
        send_byte(8'h00, 16'd3);
        drain_encoder();
        write_reg(esfe_pkg::REG_COMMAND_CODE, 32'h1);
        write_reg(esfe_pkg::REG_SUB_CODE, 32'h2);
        send_byte(8'h11, 16'h0000);
        send_byte(8'h12, 16'd1);
        drain_encoder();
    endtask

    // Full segments, a one-byte tail segment, and a length cut at a boundary
    task automatic test_segment_boundary();
        write_reg(esfe_pkg::REG_COMMAND_CODE, 32'hFF);
        write_reg(esfe_pkg::REG_SUB_CODE, 32'h0);
        send_random_bytes(129, 16'd129);
        send_random_bytes(128, 16'd300);
        send_byte(draw_data(), 16'd100);
        drain_encoder();
    endtask

    // Switch framing mode in the middle of a message
    task automatic test_mode_switch();
        send_random_bytes(3, 16'd10);
        drain_encoder();
        write_reg(esfe_pkg::REG_SPLIT_MODE, 32'h0);
        send_random_bytes(3, 16'd10);
        drain_encoder();
        write_reg(esfe_pkg::REG_SPLIT_MODE, 32'h1);
        send_random_bytes(4, 16'd10);
        drain_encoder();
        write_reg(esfe_pkg::REG_SPLIT_MODE, 32'h0);
        send_random_bytes(2, 16'd6);
        drain_encoder();
        write_reg(esfe_pkg::REG_SPLIT_MODE, 32'h1);
        send_random_bytes(4, 16'd6);
        drain_encoder();
    endtask

    // Hold the output off while input keeps coming, then pause until empty
    task automatic test_backpressure();
        hold_off = 1'b1;
        send_random_bytes(40, 16'd40);
        drain_encoder();
        send_random_bytes(5, 16'd5);
        drain_encoder();
    endtask

    // Random settings per phase; mostly complete messages, some noise
    task automatic test_random_traffic();
        int unsigned first;
        int unsigned len;
        int unsigned count;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            drain_encoder();
            write_reg(esfe_pkg::REG_SPLIT_MODE, $urandom_range(0, 1));
            write_reg(esfe_pkg::REG_COMMAND_CODE, 32'(draw_code()));
            write_reg(esfe_pkg::REG_SUB_CODE, 32'(draw_code()));
            quiet = ($urandom_range(0, 4) == 0);
            repeat (6)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        // large or zero length, ended early by a smaller one
                        count = $urandom_range(1, 5);
                        send_random_bytes(count, 16'($urandom_range(0, 65535)));
                        send_byte(draw_data(), 16'($urandom_range(1, count)));
                    end
                    2:
                        send_byte(draw_data(), 16'($urandom_range(0, 65535)));
                    default:
                    begin
                        if ($urandom_range(0, 39) == 0)
                            len = $urandom_range(250, 260);
                        else if ($urandom_range(0, 9) == 0)
                            len = $urandom_range(126, 131);
                        else
                            len = $urandom_range(1, 14);
                        send_random_bytes(len, 16'(len));
                    end
                endcase
            end
        end
        quiet = 1'b0;
        drain_encoder();
    endtask

    initial
    begin : sequencer
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= 8'h00;
        in_ch.message_length <= 16'd0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        rst_n                <= 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_plain_frames();
        test_split_frames();
        test_segment_boundary();
        test_mode_switch();
        test_backpressure();
        test_random_traffic();

        drain_encoder();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_serial_q.size() != 0)
            report_mismatch("beats still pending", pending_serial_q.size(), 0);
        if (mismatches == 0)
            $display("escaped_segmented_frame_encoder: match");
        else
            $display("escaped_segmented_frame_encoder: mismatch");
        $finish;
    end

endmodule
